/* rtl/csp_pkg.sv */
// Shared constants, codes and control structs for the cyclic schedule position lookup.
package csp_pkg;

  // Table depth and derived widths
  localparam int unsigned MaxSegments = 256;
  localparam int unsigned CntW        = $clog2(MaxSegments + 1);
  localparam int unsigned IdxW        = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;

  // Fixed field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned DurW    = 20;
  localparam int unsigned NowW    = 32;
  localparam int unsigned TotW    = 28;
  localparam int unsigned StW     = 2;
  localparam int unsigned SegIdxW = 8;
  localparam int unsigned StepW   = $clog2(NowW + 1);

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic append;
    logic load_imm;
    logic div_start;
    logic div_step;
    logic scan_start;
    logic scan_step;
    logic load_scan;
  } csp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic total_zero;
    logic div_done;
    logic scan_done;
  } csp_stat_t;

endpackage

/* rtl/csp_dpath.sv */
// Datapath: duration table, running total, bit-serial modulo, table walk and result register.
module csp_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  csp_pkg::csp_cmd_t           cmd_i,
  output csp_pkg::csp_stat_t          stat_o,
  input  logic [csp_pkg::OpW-1:0]     opcode_i,
  input  logic [csp_pkg::DurW-1:0]    segment_duration_i,
  input  logic [csp_pkg::NowW-1:0]    now_secs_i,
  output logic [csp_pkg::StW-1:0]     status_o,
  output logic [csp_pkg::SegIdxW-1:0] segment_index_o,
  output logic [csp_pkg::DurW-1:0]    seek_secs_o
);
  import csp_pkg::*;

  // Table storage
  logic [DurW-1:0] mem [MaxSegments];

  // Control state
  logic [CntW-1:0]  count_q;
  logic [TotW-1:0]  total_q;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  addr_q;
  logic             rd_vld_q;
  logic             hit_q;

  // Working data
  logic [NowW-1:0] dvd_q;
  logic [TotW-1:0] rem_q;
  logic [DurW-1:0] rdata_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [IdxW-1:0] hit_idx_q;

  // Result register
  logic [StW-1:0]     status_q;
  logic [SegIdxW-1:0] index_q;
  logic [DurW-1:0]    seek_q;

  logic                    full;
  logic                    rd_issue;
  logic [TotW:0]           trial;
  logic [TotW:0]           diff;
  logic [TotW-1:0]         rem_div;
  logic [TotW-1:0]         dur_ext;
  logic                    lt;
  logic                    cmp_act;
  logic [IdxW+SegIdxW-1:0] idx_wide;
  logic [StW-1:0]          imm_status;

  assign full     = (count_q == CntW'(MaxSegments));
  assign rd_issue = cmd_i.scan_step && (addr_q < count_q);

  // One restoring modulo step: shift in the next dividend bit, subtract if it fits
  assign trial   = {rem_q, dvd_q[NowW-1]};
  assign diff    = trial - {1'b0, total_q};
  assign rem_div = diff[TotW] ? trial[TotW-1:0] : diff[TotW-1:0];

  // Compare the remainder with the entry read last cycle
  assign dur_ext = {{(TotW-DurW){1'b0}}, rdata_q};
  assign lt      = (rem_q < dur_ext);
  assign cmp_act = cmd_i.scan_step && rd_vld_q && !hit_q;

  assign stat_o.total_zero = (total_q == '0);
  assign stat_o.div_done   = (step_q == StepW'(NowW));
  assign stat_o.scan_done  = hit_q || (!rd_vld_q && (addr_q >= count_q));

  // Immediate result for clear, append, empty query and unused codes
  always_comb begin
    unique case (opcode_i)
      OP_CLEAR:  imm_status = ST_OK;
      OP_APPEND: imm_status = full ? ST_FULL : ST_OK;
      OP_QUERY:  imm_status = ST_EMPTY;
      default:   imm_status = ST_OK;
    endcase
  end

  assign idx_wide = {{SegIdxW{1'b0}}, hit_idx_q};

  // Hold table bookkeeping and walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      total_q  <= '0;
      step_q   <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        total_q <= '0;
      end else if (cmd_i.append && !full) begin
        count_q <= count_q + 1'b1;
        total_q <= total_q + {{(TotW-DurW){1'b0}}, segment_duration_i};
      end
      if (cmd_i.div_start) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        addr_q   <= '0;
        rd_vld_q <= 1'b0;
        hit_q    <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (rd_issue) begin
          addr_q <= addr_q + 1'b1;
        end
        rd_vld_q <= rd_issue;
        if (cmp_act && lt) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Write appended durations, read one entry per walk cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[count_q[IdxW-1:0]] <= segment_duration_i;
    end
    if (rd_issue) begin
      rdata_q <= mem[addr_q[IdxW-1:0]];
    end
  end

  // Advance dividend, remainder and walk indices
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= now_secs_i;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[NowW-2:0], 1'b0};
      rem_q <= rem_div;
    end else if (cmp_act && !lt) begin
      rem_q <= rem_q - dur_ext;
    end
    if (rd_issue) begin
      rd_idx_q <= addr_q[IdxW-1:0];
    end
    if (cmp_act && lt) begin
      hit_idx_q <= rd_idx_q;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_imm) begin
      status_q <= imm_status;
      index_q  <= '0;
      seek_q   <= '0;
    end else if (cmd_i.load_scan) begin
      status_q <= ST_OK;
      index_q  <= hit_q ? idx_wide[SegIdxW-1:0] : '0;
      seek_q   <= hit_q ? rem_q[DurW-1:0] : '0;
    end
  end

  assign status_o        = status_q;
  assign segment_index_o = index_q;
  assign seek_secs_o     = seek_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSegments))
    else $error("entry count beyond table depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && rd_vld_q) |->
      ({{(CntW-IdxW){1'b0}}, rd_idx_q} < count_q) || (CntW == IdxW))
    else $error("walk read past the last valid entry");

  a_hit_seek_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q && cmd_i.load_scan) |-> (rem_q[TotW-1:DurW] == '0))
    else $error("seek offset does not fit the field");

endmodule

/* rtl/csp_ctrl.sv */
// Controller: sequences accept, modulo, table walk and result hand-off.
module csp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [csp_pkg::OpW-1:0] opcode_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output csp_pkg::csp_cmd_t       cmd_o,
  input  csp_pkg::csp_stat_t      stat_i
);
  import csp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_FIN
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  logic     accept;
  csp_cmd_t cmd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Decode next state and commands
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.load_imm = 1'b1;
            end
            OP_APPEND: begin
              cmd.append   = 1'b1;
              cmd.load_imm = 1'b1;
            end
            OP_QUERY: begin
              if (stat_i.total_zero) begin
                cmd.load_imm = 1'b1;
              end else begin
                cmd.div_start = 1'b1;
                state_d       = S_DIV;
              end
            end
            default: cmd.load_imm = 1'b1;
          endcase
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd.scan_start = 1'b1;
          state_d        = S_SCAN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_FIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_scan = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Set result valid on load, drop it when taken
  always_comb begin
    if (cmd.load_imm || cmd.load_scan) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Hold state and the registered valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  // Checks
  a_query_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_QUERY) && !stat_i.total_zero) |=> (state_q == S_DIV))
    else $error("query with non-zero total did not start the modulo");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) && !stat_i.div_done) |=> (state_q == S_DIV))
    else $error("modulo left before all steps were done");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input taken while a query is in progress");

endmodule

/* rtl/cyclic_schedule_position_lookup.sv */
// Top level of the cyclic schedule position lookup: controller plus datapath.
//
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+---------------------------------------------
// in      | input     | in_valid_i / in_ready_o    | opcode_i, segment_duration_i, now_secs_i
// out     | output    | out_valid_o / out_ready_i  | status_o, segment_index_o, seek_secs_o
//
// Clear, append, empty query and unused codes: result registered at accept.
// Query: accept, modulo over the 32 dividend bits, then walk start, table walk (one table
//   read a cycle, up to the first hit or the last entry), then hand-off once the output is free.
// Reset clears entry count, total and control; the table contents are not cleared.
// The input stalls while a query is in progress or an untaken result holds the output.
module cyclic_schedule_position_lookup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [csp_pkg::OpW-1:0]     opcode_i,
  input  logic [csp_pkg::DurW-1:0]    segment_duration_i,
  input  logic [csp_pkg::NowW-1:0]    now_secs_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csp_pkg::StW-1:0]     status_o,
  output logic [csp_pkg::SegIdxW-1:0] segment_index_o,
  output logic [csp_pkg::DurW-1:0]    seek_secs_o
);
  import csp_pkg::*;

  csp_cmd_t  cmd;
  csp_stat_t stat;

  // Sequence each transaction
  csp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Table, modulo, walk and result register
  csp_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .opcode_i           (opcode_i),
    .segment_duration_i (segment_duration_i),
    .now_secs_i         (now_secs_i),
    .status_o           (status_o),
    .segment_index_o    (segment_index_o),
    .seek_secs_o        (seek_secs_o)
  );

endmodule
